// ===== rtl/owtemp_pkg.sv =====
// Package for the one-wire temperature read master: payload words, phase codes,
// register indexes and the slot timing constants. No dependencies.
`timescale 1ns / 1ps
package owtemp_pkg;

   typedef struct packed {
      logic op;
      logic line_level;
   } req_word_type;

   typedef struct packed {
      logic        drive_low;
      logic        busy_res;
      logic        done_res;
      logic [15:0] temperature_raw;
   } rsp_word_type;

   typedef enum logic [1:0] {
      REG_RESET_LOW   = 2'd0,
      REG_RESET_RECOV = 2'd1,
      REG_CONVERT     = 2'd2,
      REG_UNUSED      = 2'd3
   } reg_index_type;

   typedef enum logic [7:0] {
      PH_IDLE      = 8'b0000_0001,
      PH_RST_LOW   = 8'b0000_0010,
      PH_PRES_LOW  = 8'b0000_0100,
      PH_PRES_HIGH = 8'b0000_1000,
      PH_RECOVER   = 8'b0001_0000,
      PH_WRITE     = 8'b0010_0000,
      PH_CONVERT   = 8'b0100_0000,
      PH_READ      = 8'b1000_0000
   } phase_type;

   localparam int CFG_WIDTH = 20;

   localparam logic [11:0] RESET_LOW_DEFAULT   = 12'd700;
   localparam logic [11:0] RESET_RECOV_DEFAULT = 12'd480;
   localparam logic [19:0] CONVERT_DEFAULT     = 20'd750000;

   localparam int WR1_LOW   = 10;
   localparam int WR1_SLOT  = 77;
   localparam int WR0_LOW   = 65;
   localparam int WR0_SLOT  = 67;
   localparam int RD_LOW    = 2;
   localparam int RD_SAMPLE = 12;
   localparam int RD_SLOT   = 72;
   localparam int BYTE_BITS = 8;

   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_SP  = 8'hBE;

   function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0:    b = CMD_SKIP_ROM;
         2'd1:    b = CMD_CONVERT;
         2'd2:    b = CMD_SKIP_ROM;
         default: b = CMD_READ_SP;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/onewire_temperature_read_master_unit.sv =====
// Top level of the one-wire temperature read master: sequencer, timers and result register.
// Depends on owtemp_pkg.
`timescale 1ns / 1ps
// One word enters per clock: each request word is a start or a one-microsecond tick with the
// sampled bus level, and each yields exactly one response word carrying the open-drain drive,
// busy, done and the last read temperature word. The whole sequencer step for a word is one
// pass of next-state logic from the phase, timer and counters into the response register, so
// the sustained rate is one word per cycle; req_ready drops only while a response waits on a
// stalled rsp_ready. The slot timer is TIMER_BITS wide; only the conversion length saturates at its range.
module onewire_temperature_read_master_unit #(
   parameter int TIMER_BITS = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  owtemp_pkg::req_word_type        req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output owtemp_pkg::rsp_word_type        rsp_data,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [owtemp_pkg::CFG_WIDTH-1:0] csr_wdata
);
   import owtemp_pkg::*;

   localparam int CW = (TIMER_BITS > CFG_WIDTH) ? TIMER_BITS : CFG_WIDTH;
   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

   logic [11:0]           reset_low_ff;
   logic [11:0]           reset_recov_ff;
   logic [19:0]           convert_ff;

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [3:0]            bit_count_ff, bit_count_in;
   logic [1:0]            cmd_idx_ff, cmd_idx_in;
   logic [15:0]           shift_ff, shift_in;
   logic [15:0]           result_ff, result_in;

   logic                  rsp_valid_ff;
   rsp_word_type          rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  done;
   logic [TIMER_BITS-1:0] tick_next;
   logic [TIMER_BITS-1:0] convert_limit;
   logic [CW-1:0]         convert_wide;
   logic [3:0]            bit_next;

   function automatic logic drive_of(input phase_type ph, input logic [TIMER_BITS-1:0] t,
                                     input logic [1:0] ci, input logic [3:0] bc);
      logic [7:0] b;
      logic       d;
      b = cmd_byte(ci);
      unique case (ph)
         PH_RST_LOW: d = 1'b1;
         PH_WRITE:   d = b[bc[2:0]] ? (t < TIMER_BITS'(WR1_LOW)) : (t < TIMER_BITS'(WR0_LOW));
         PH_READ:    d = t < TIMER_BITS'(RD_LOW);
         default:    d = 1'b0;
      endcase
      return d;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign tick_next     = timer_ff + TIMER_BITS'(1);
   assign convert_wide  = CW'(convert_ff);
   assign convert_limit = (convert_wide > CW'(TMAX)) ? TMAX : TIMER_BITS'(convert_wide);
   assign bit_next      = bit_count_ff + 4'd1;

   always_comb begin
      logic [7:0] b;
      phase_in     = phase_ff;
      timer_in     = timer_ff;
      bit_count_in = bit_count_ff;
      cmd_idx_in   = cmd_idx_ff;
      shift_in     = shift_ff;
      result_in    = result_ff;
      done         = 1'b0;
      b            = cmd_byte(cmd_idx_ff);
      if (req_data.op) begin
         if (phase_ff == PH_IDLE) begin
            cmd_idx_in   = 2'd0;
            bit_count_in = 4'd0;
            shift_in     = 16'd0;
            timer_in     = '0;
            phase_in     = (reset_low_ff == 12'd0) ? PH_PRES_LOW : PH_RST_LOW;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: phase_in = PH_IDLE;
            PH_RST_LOW: begin
               timer_in = tick_next;
               if (tick_next >= TIMER_BITS'(reset_low_ff)) begin
                  timer_in = '0;
                  phase_in = PH_PRES_LOW;
               end
            end
            PH_PRES_LOW: begin
               if (!req_data.line_level) phase_in = PH_PRES_HIGH;
            end
            PH_PRES_HIGH: begin
               if (req_data.line_level) begin
                  timer_in     = '0;
                  bit_count_in = 4'd0;
                  phase_in     = (reset_recov_ff == 12'd0) ? PH_WRITE : PH_RECOVER;
               end
            end
            PH_RECOVER: begin
               timer_in = tick_next;
               if (tick_next >= TIMER_BITS'(reset_recov_ff)) begin
                  timer_in     = '0;
                  bit_count_in = 4'd0;
                  phase_in     = PH_WRITE;
               end
            end
            PH_WRITE: begin
               timer_in = tick_next;
               if (tick_next >= (b[bit_count_ff[2:0]] ? TIMER_BITS'(WR1_SLOT)
                                                      : TIMER_BITS'(WR0_SLOT))) begin
                  timer_in     = '0;
                  bit_count_in = bit_next;
                  if (bit_next >= 4'(BYTE_BITS)) begin
                     bit_count_in = 4'd0;
                     priority if (cmd_idx_ff == 2'd1) begin
                        cmd_idx_in = 2'd2;
                        if (convert_limit == '0) begin
                           phase_in = (reset_low_ff == 12'd0) ? PH_PRES_LOW : PH_RST_LOW;
                        end else begin
                           phase_in = PH_CONVERT;
                        end
                     end else if (cmd_idx_ff == 2'd3) begin
                        shift_in = 16'd0;
                        phase_in = PH_READ;
                     end else begin
                        cmd_idx_in = cmd_idx_ff + 2'd1;
                     end
                  end
               end
            end
            PH_CONVERT: begin
               timer_in = tick_next;
               if (tick_next >= convert_limit) begin
                  timer_in = '0;
                  phase_in = (reset_low_ff == 12'd0) ? PH_PRES_LOW : PH_RST_LOW;
               end
            end
            PH_READ: begin
               if (timer_ff == TIMER_BITS'(RD_SAMPLE)) begin
                  shift_in = shift_ff | (16'(req_data.line_level) << bit_count_ff);
               end
               timer_in = tick_next;
               if (tick_next >= TIMER_BITS'(RD_SLOT)) begin
                  timer_in = '0;
                  if (bit_count_ff == 4'd15) begin
                     bit_count_in = 4'd0;
                     result_in    = shift_in;
                     phase_in     = PH_IDLE;
                     done         = 1'b1;
                  end else begin
                     bit_count_in = bit_next;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
      rsp_data_in.drive_low       = req_data.op
         ? drive_of(phase_in, timer_in, cmd_idx_in, bit_count_in)
         : drive_of(phase_ff, timer_ff, cmd_idx_ff, bit_count_ff);
      rsp_data_in.busy_res        = phase_in != PH_IDLE;
      rsp_data_in.done_res        = done;
      rsp_data_in.temperature_raw = result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff   <= RESET_LOW_DEFAULT;
         reset_recov_ff <= RESET_RECOV_DEFAULT;
         convert_ff     <= CONVERT_DEFAULT;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_RESET_LOW:   reset_low_ff   <= csr_wdata[11:0];
            REG_RESET_RECOV: reset_recov_ff <= csr_wdata[11:0];
            REG_CONVERT:     convert_ff     <= csr_wdata[19:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         timer_ff     <= '0;
         bit_count_ff <= 4'd0;
         cmd_idx_ff   <= 2'd0;
         shift_ff     <= 16'd0;
         result_ff    <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            timer_ff     <= timer_in;
            bit_count_ff <= bit_count_in;
            cmd_idx_ff   <= cmd_idx_in;
            shift_ff     <= shift_in;
            result_ff    <= result_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTH
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("done reported while still busy");

   a_write_bits: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WRITE |-> bit_count_ff < 4'd8)
      else $error("write bit count past one byte");

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.op && phase_ff == PH_IDLE |=> phase_ff != PH_IDLE)
      else $error("start did not launch a sequence");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted word produced no response");

   a_result_on_done: assert property (@(posedge clock) disable iff (reset)
      accept && done |=> rsp_data.temperature_raw == $past(shift_in))
      else $error("result word does not match assembled bits");
`endif

endmodule
